/* hdl/hfc_pkg.sv */
// hfc_pkg: shared constants and field types for the half/single converter.
// No dependencies; used by hfc_h2s, hfc_s2h and half_float_converter_core.
package hfc_pkg;

    typedef logic [31:0] word32_t;
    typedef logic [15:0] word16_t;

    // direction codes carried on the func field
    localparam logic FUNC_H2S = 1'b0;
    localparam logic FUNC_S2H = 1'b1;

    localparam logic [15:0] SIGN16   = 16'h8000;
    localparam logic [15:0] EXP16    = 16'h7C00;
    localparam logic [15:0] MAN16    = 16'h03FF;
    localparam logic [31:0] SUBMASK  = 32'h007FE000;
    localparam logic [31:0] RND      = 32'h00001000;
    localparam logic [31:0] EXP32    = 32'h7F800000;
    localparam logic [31:0] MAN32    = 32'h007FFFFF;
    localparam logic [23:0] SUBBIAS  = 24'h7FF000;
    localparam logic [15:0] SAT      = 16'h7FFF;
    localparam logic [31:0] SIGN32   = 32'h80000000;
    localparam logic [7:0]  REBIAS   = 8'd112;
    localparam logic [7:0]  SUBOFF   = 8'd37;

    // exponent window edges for single to half
    localparam logic [7:0]  SUB_LO   = 8'd102;
    localparam logic [7:0]  SAT_EXP  = 8'd143;
    // subnormal shift is SUB_SHIFT_BASE - e
    localparam logic [7:0]  SUB_SHIFT_BASE = 8'd125;
    // single exponent of a subnormal half whose leading one is at bit 0
    localparam logic [7:0]  SUBN_EXP_BASE  = 8'd140 - SUBOFF;

endpackage

/* hdl/hfc_h2s.sv */
// hfc_h2s: combinational half (1-5-10) to single (1-8-23) conversion.
// Depends on hfc_pkg.
module hfc_h2s (
    input  hfc_pkg::word16_t half_in,
    output hfc_pkg::word32_t single_out
);

    // leading-one position of a 10-bit mantissa, last hit wins
    function automatic logic [3:0] lead_one(input logic [9:0] x);
        logic [3:0] p;
        p = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (x[i]) begin
                p = 4'(i);
            end
        end
        return p;
    endfunction

    logic       sign;
    logic [4:0] exp_h;
    logic [9:0] man_h;
    logic [3:0] lead;
    logic [3:0] norm_sh;
    logic [9:0] man_norm;
    logic [7:0] exp_norm;
    logic [7:0] exp_sub;

    assign sign     = |(half_in & hfc_pkg::SIGN16);
    assign exp_h    = half_in[14:10];
    assign man_h    = half_in[9:0];
    assign exp_norm = {3'b000, exp_h} + hfc_pkg::REBIAS;

    // subnormal: leading one moves to the hidden bit and drops out
    assign lead     = lead_one(man_h);
    assign norm_sh  = 4'd10 - lead;
    assign man_norm = man_h << norm_sh;
    assign exp_sub  = hfc_pkg::SUBN_EXP_BASE + {4'b0000, lead};

    always_comb begin
        if (exp_h != 5'd0) begin
            single_out = {sign, exp_norm, man_h, 13'd0};
        end else if (man_h != 10'd0) begin
            single_out = {sign, exp_sub, man_norm, 13'd0} & (hfc_pkg::SIGN32
                         | hfc_pkg::EXP32 | hfc_pkg::SUBMASK);
        end else begin
            single_out = {sign, 31'd0};
        end
    end

endmodule

/* hdl/hfc_s2h.sv */
// hfc_s2h: combinational single to half conversion with rounding,
// subnormal output, saturation and flush to zero. Depends on hfc_pkg.
module hfc_s2h (
    input  hfc_pkg::word32_t single_in,
    output hfc_pkg::word32_t half_out
);

    logic [31:0] b;
    logic [7:0]  e;
    logic [22:0] m;
    logic [7:0]  e_off;
    logic [7:0]  sh_full;
    logic [4:0]  sh;
    logic [23:0] sub_sum;
    logic [23:0] sub_shr;
    logic [11:0] sub_rnd;
    logic [15:0] r;

    // rounding add; carry may ripple into exponent and sign
    assign b       = single_in + hfc_pkg::RND;
    assign e       = b[30:23];
    assign m       = b[22:0];
    assign e_off   = e - hfc_pkg::REBIAS;
    assign sh_full = hfc_pkg::SUB_SHIFT_BASE - e;
    assign sh      = sh_full[4:0];
    assign sub_sum = hfc_pkg::SUBBIAS + {1'b0, m};
    assign sub_shr = sub_sum >> sh;
    assign sub_rnd = sub_shr[11:0] + 12'd1;

    always_comb begin
        r = {b[31], 15'd0};
        if (e > hfc_pkg::REBIAS) begin
            r = r | (({e_off[5:0], 10'd0}) & hfc_pkg::EXP16) | {6'd0, m[22:13]};
        end
        if (e <= hfc_pkg::REBIAS && e >= hfc_pkg::SUB_LO) begin
            r = r | {5'd0, sub_rnd[11:1]};
        end
        if (e > hfc_pkg::SAT_EXP) begin
            r = r | hfc_pkg::SAT;
        end
    end

    assign half_out = {16'd0, r};

endmodule

/* hdl/half_float_converter_core.sv */
// half_float_converter_core: top level, input register, conversion logic,
// result register. Depends on hfc_pkg, hfc_h2s, hfc_s2h.
//
//  channel | ports                          | direction | word
//  --------+--------------------------------+-----------+-----------------------
//  input   | s_valid s_ready s_func s_value | in        | func (1b), value (32b)
//  result  | m_valid m_ready m_result       | out       | result (32b)
//
// One word per cycle sustained while m_ready is high; an accepted word passes
// the input register, then the conversion logic and result register, to m_valid.
// aresetn is synchronous and active low; it clears the two valid flags only.
// A stalled result register holds its word; the input register keeps taking
// a new word whenever it empties into the result stage in the same cycle,
// so s_ready drops only when both stages are full and m_ready is low.
module half_float_converter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result
);

    // stage 1: captured input word
    logic        in_vld_reg, in_vld_next;
    logic        func_reg;
    logic [31:0] value_reg;

    // stage 2: converted word
    logic        out_vld_reg, out_vld_next;
    logic        out_func_reg;
    logic [31:0] result_reg;
    logic [31:0] result_next;

    logic        s_accept;
    logic        advance;

    hfc_pkg::word32_t h2s_out;
    hfc_pkg::word32_t s2h_out;

    // stage 1 moves on when stage 2 is empty or being drained
    assign advance  = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready  = !in_vld_reg || advance;
    assign s_accept = s_valid && s_ready;

    assign in_vld_next  = s_ready ? s_valid : in_vld_reg;
    assign out_vld_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_vld_reg);

    // both directions are computed; func selects
    hfc_h2s u_h2s (
        .half_in    (value_reg[15:0]),
        .single_out (h2s_out)
    );

    hfc_s2h u_s2h (
        .single_in  (value_reg),
        .half_out   (s2h_out)
    );

    always_comb begin
        case (func_reg)
            hfc_pkg::FUNC_H2S: result_next = h2s_out;
            hfc_pkg::FUNC_S2H: result_next = s2h_out;
            default:           result_next = h2s_out;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg  <= s_func;
            value_reg <= s_value;
        end
        if (advance) begin
            result_reg   <= result_next;
            out_func_reg <= func_reg;
        end
    end

    assign m_valid  = out_vld_reg;
    assign m_result = result_reg;

    // an empty result stage never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_vld_reg |-> s_ready)
        else $error("s_ready low with empty result stage");

    // both stages full and stalled: no new word may enter
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && out_vld_reg && !m_ready) |-> !s_ready)
        else $error("input taken while pipeline full");

    // an accepted word lands in stage 1
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> in_vld_reg)
        else $error("accepted word lost");

    // half results carry zero in the upper 16 bits
    a_half_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_func_reg == hfc_pkg::FUNC_S2H) |-> m_result[31:16] == 16'd0)
        else $error("half result has nonzero upper bits");

endmodule
